// ----- sv/chd_pkg.sv -----
// shared types, constants and helper functions for the chunked body decoder
package chd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;

    localparam logic [1:0] TRAILER_LEN = 2'd2;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_VT = 8'h0b;
    localparam logic [7:0] CH_FF = 8'h0c;
    localparam logic [7:0] CH_CR = 8'h0d;

    typedef enum logic [1:0] {
        PH_SIZE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_WS   = 2'd0,
        ST_ZERO = 2'd1,
        ST_DIG  = 2'd2,
        ST_STOP = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        ES_ZERO  = 2'd0,
        ES_SIZE  = 2'd1,
        ES_DATA  = 2'd2,
        ES_TRAIL = 2'd3
    } end_status_t;

    // result of one word, before the output register
    typedef struct packed {
        logic        valid;
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        done_res;
        end_status_t end_status;
    } res_t;

    // {is hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= CH_0 && c <= CH_9) begin
                r = {1'b1, 4'(c - CH_0)};
            end else if (c >= CH_LA && c <= CH_LF_HEX) begin
                r = {1'b1, 4'(c - CH_LA + 8'd10)};
            end else if (c >= CH_UA && c <= CH_UF) begin
                r = {1'b1, 4'(c - CH_UA + 8'd10)};
            end
            return r;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

endpackage

// ----- sv/chd_line_parse.sv -----
// size line character parser: digit stage and size accumulation for one character
module chd_line_parse #(
    parameter int SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
    input  chd_pkg::stage_t        stage,
    input  logic [7:0]             c,
    input  logic [SIZE_WIDTH-1:0]  accum,
    output chd_pkg::stage_t        stage_out,
    output logic [SIZE_WIDTH-1:0]  accum_out
);

    logic [4:0]            h;
    logic                  sat;
    logic [SIZE_WIDTH-1:0] added;

    assign h     = chd_pkg::hex_digit(c);
    // saturate once the top nibble is in use
    assign sat   = |accum[SIZE_WIDTH-1:SIZE_WIDTH-4];
    assign added = sat ? {SIZE_WIDTH{1'b1}} : {accum[SIZE_WIDTH-5:0], h[3:0]};

    always_comb begin
        stage_out = stage;
        accum_out = accum;
        unique case (stage)
            chd_pkg::ST_WS: begin
                if (chd_pkg::is_space(c)) begin
                    stage_out = chd_pkg::ST_WS;
                end else if (c == chd_pkg::CH_0) begin
                    stage_out = chd_pkg::ST_ZERO;
                end else if (h[4]) begin
                    accum_out = added;
                    stage_out = chd_pkg::ST_DIG;
                end else begin
                    stage_out = chd_pkg::ST_STOP;
                end
            end
            chd_pkg::ST_ZERO: begin
                if (c == chd_pkg::CH_LX || c == chd_pkg::CH_UX) begin
                    stage_out = chd_pkg::ST_DIG;
                end else if (h[4]) begin
                    accum_out = added;
                    stage_out = chd_pkg::ST_DIG;
                end else begin
                    stage_out = chd_pkg::ST_STOP;
                end
            end
            chd_pkg::ST_DIG: begin
                if (h[4]) begin
                    accum_out = added;
                end else begin
                    stage_out = chd_pkg::ST_STOP;
                end
            end
            chd_pkg::ST_STOP: begin
                stage_out = chd_pkg::ST_STOP;
            end
            default: begin
                stage_out = stage;
            end
        endcase
    end

endmodule

// ----- sv/chd_core.sv -----
// decoder state registers and per-word next-state and result logic
module chd_core #(
    parameter int SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    in_byte,
    input  logic          is_last,
    output chd_pkg::res_t res
);

    chd_pkg::phase_t       phase_reg, phase_next;
    chd_pkg::stage_t       stage_reg, stage_next;
    logic [SIZE_WIDTH-1:0] accum_reg, accum_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;
    logic [SIZE_WIDTH-1:0] left_dec;
    logic                  prev_cr_reg, prev_cr_next;
    logic [1:0]            trail_reg, trail_next;
    logic [1:0]            trail_dec;

    chd_pkg::stage_t       stage_in;
    chd_pkg::stage_t       stage_pc;
    logic [SIZE_WIDTH-1:0] accum_pc;
    logic                  is_cr;
    logic                  line_end;

    assign is_cr    = (in_byte == chd_pkg::CH_CR);
    assign line_end = prev_cr_reg && (in_byte == chd_pkg::CH_LF);
    // a held back lone cr is whitespace before digits and a stop after them
    assign stage_in = (prev_cr_reg && stage_reg != chd_pkg::ST_WS) ?
                      chd_pkg::ST_STOP : stage_reg;
    assign left_dec  = left_reg - {{(SIZE_WIDTH-1){1'b0}}, 1'b1};
    assign trail_dec = trail_reg - 2'd1;

    chd_line_parse #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_parse (
        .stage     (stage_in),
        .c         (in_byte),
        .accum     (accum_reg),
        .stage_out (stage_pc),
        .accum_out (accum_pc)
    );

    // next state
    always_comb begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        accum_next   = accum_reg;
        left_next    = left_reg;
        prev_cr_next = prev_cr_reg;
        trail_next   = trail_reg;
        unique case (phase_reg)
            chd_pkg::PH_SIZE: begin
                if (line_end) begin
                    prev_cr_next = 1'b0;
                    phase_next   = (accum_reg == '0) ? chd_pkg::PH_DONE : chd_pkg::PH_DATA;
                    left_next    = accum_reg;
                    accum_next   = '0;
                    stage_next   = chd_pkg::ST_WS;
                end else begin
                    prev_cr_next = is_cr;
                    if (is_cr) begin
                        stage_next = stage_in;
                    end else begin
                        stage_next = stage_pc;
                        accum_next = accum_pc;
                    end
                end
            end
            chd_pkg::PH_DATA: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = chd_pkg::PH_TRAIL;
                    trail_next = chd_pkg::TRAILER_LEN;
                end
            end
            chd_pkg::PH_TRAIL: begin
                trail_next = trail_dec;
                if (trail_dec == 2'd0) begin
                    phase_next = chd_pkg::PH_SIZE;
                end
            end
            chd_pkg::PH_DONE: begin
                phase_next = chd_pkg::PH_DONE;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // result of the current word
    always_comb begin
        res            = '0;
        res.has_byte   = (phase_reg == chd_pkg::PH_DATA);
        res.done_res   = is_last;
        res.valid      = res.has_byte || is_last;
        res.out_byte   = res.has_byte ? in_byte : 8'd0;
        res.end_status = chd_pkg::ES_ZERO;
        if (is_last) begin
            unique case (phase_next)
                chd_pkg::PH_DONE:  res.end_status = chd_pkg::ES_ZERO;
                chd_pkg::PH_SIZE:  res.end_status = chd_pkg::ES_SIZE;
                chd_pkg::PH_DATA:  res.end_status = chd_pkg::ES_DATA;
                chd_pkg::PH_TRAIL: res.end_status = chd_pkg::ES_TRAIL;
                default:           res.end_status = chd_pkg::ES_ZERO;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= chd_pkg::PH_SIZE;
            stage_reg   <= chd_pkg::ST_WS;
            accum_reg   <= '0;
            left_reg    <= '0;
            prev_cr_reg <= 1'b0;
            trail_reg   <= 2'd0;
        end else if (step) begin
            if (is_last) begin
                // body finished: back to the reset state for the next body
                phase_reg   <= chd_pkg::PH_SIZE;
                stage_reg   <= chd_pkg::ST_WS;
                accum_reg   <= '0;
                left_reg    <= '0;
                prev_cr_reg <= 1'b0;
                trail_reg   <= 2'd0;
            end else begin
                phase_reg   <= phase_next;
                stage_reg   <= stage_next;
                accum_reg   <= accum_next;
                left_reg    <= left_next;
                prev_cr_reg <= prev_cr_next;
                trail_reg   <= trail_next;
            end
        end
    end

endmodule

// ----- sv/http_chunked_body_decoder_unit.sv -----
// top level of the http chunked transfer body decoder
//
// usage
//   input channel s_*: one word per encoded body byte (s_in_byte), with
//   s_is_last marking the final byte of the body
//   output channel m_*: a word for every payload byte (m_has_byte = 1) and
//   one for the final input byte (m_done_res = 1, m_end_status says where
//   the body stopped); other input bytes give no output word
// datapath and throughput
//   an accepted word sits in the input register, is decoded by the core
//   and lands in the output register when the input register advances,
//   so its result is shown from the output register
//   one byte per cycle while the output is not stalled: the size shift-add
//   and the count decrements each finish between the input and output registers
// reset
//   aresetn is synchronous, active low; it clears both valid flags and the
//   decoder state (size line phase, empty accumulator)
// stalls
//   while m_ready is low the output word holds; the input register still
//   takes a byte and drains bytes that give no result, and s_ready drops
//   only when a waiting byte has a result with nowhere to go
module http_chunked_body_decoder_unit #(
    parameter int SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_done_res,
    output logic [1:0] m_end_status
);

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // output register
    logic        out_vld_reg, out_vld_next;
    chd_pkg::res_t out_reg;

    chd_pkg::res_t res;
    logic          out_free;
    logic          in_adv;
    logic          s_take;

    // core sees the registered word and updates its state when it advances
    chd_core #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_adv),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .res     (res)
    );

    // output slot is free if empty or being taken this cycle
    assign out_free = !out_vld_reg || m_ready;
    // a word with no result never waits for the output side
    assign in_adv   = in_vld_reg && (!res.valid || out_free);
    assign s_ready  = !in_vld_reg || in_adv;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_take) begin
            in_vld_next = 1'b1;
        end else if (in_adv) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (in_adv && res.valid) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_is_last;
        end
        if (in_adv && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_out_byte   = out_reg.out_byte;
    assign m_has_byte   = out_reg.has_byte;
    assign m_done_res   = out_reg.done_res;
    assign m_end_status = out_reg.end_status;

endmodule

// ----- sv/chd_checker.sv -----
// port level checker for the chunked body decoder, bound to the top level
module chd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_is_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_has_byte,
    input logic       m_done_res,
    input logic [1:0] m_end_status
);

    // a stalled output word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_has_byte) && $stable(m_done_res) && $stable(m_end_status))
        else $error("stalled output word changed");

    // no output word after a reset cycle
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // every output word carries a byte or closes the body
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_has_byte || m_done_res)
        else $error("empty output word");

    // byte lane is zero when no payload byte is carried
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_out_byte == 8'd0)
        else $error("stray byte on non-payload word");

    // end status only on the closing word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_end_status == chd_pkg::ES_ZERO)
        else $error("end status on non-closing word");

endmodule

bind http_chunked_body_decoder_unit chd_checker u_chd_checker (.*);
